[hw/rtl/bbr_pkg.sv]
// Shared types, constants and helpers for the 3x3 RGB box blur.
`default_nettype none
package bbr_pkg;

  // Line store geometry
  localparam int unsigned MaxWidth = 1024;
  localparam int unsigned ColW     = $clog2(MaxWidth);

  // Register and counter widths
  localparam int unsigned WidthW      = 11;
  localparam int unsigned HeightW     = 13;
  localparam int unsigned HeightLimit = 4096;
  localparam int unsigned RowW        = 13;
  localparam int unsigned CfgDataW    = 13;

  // Channel math: a 3x3 sum of 8-bit values fits in 12 bits
  localparam int unsigned ChanW     = 8;
  localparam int unsigned NumChan   = 3;
  localparam int unsigned SumW      = 12;
  localparam int unsigned RecipW    = 13;
  localparam int unsigned RecipSh   = 16;
  // ceil(2^16 / 9); exact floor for every sum up to 9 * 255
  localparam logic [RecipW-1:0] Recip9 = RecipW'(7282);

  // Channel 2 = red, 1 = green, 0 = blue
  typedef logic [NumChan-1:0][ChanW-1:0] pix_t;
  typedef logic [NumChan-1:0][SumW-1:0]  sums_t;

  // One line store entry: the pixel two rows up and the one a row up
  typedef struct packed {
    pix_t upper;
    pix_t middle;
  } lb_word_t;

  typedef enum logic [0:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

  // floor(sum / 9) by reciprocal multiply
  function automatic logic [ChanW-1:0] div9(input logic [SumW-1:0] sum);
    logic [SumW+RecipW-1:0] prod;
    prod = {{RecipW{1'b0}}, sum} * {{SumW{1'b0}}, Recip9};
    return prod[RecipSh +: ChanW];
  endfunction

endpackage
`default_nettype wire

[hw/rtl/bbr_if.sv]
// Handshake channel interfaces: pixel input, blurred result, register write.
`default_nettype none
interface bbr_pix_if;
  logic                            valid;
  logic                            ready;
  logic                            drain;
  logic [bbr_pkg::ChanW-1:0]       in_red;
  logic [bbr_pkg::ChanW-1:0]       in_green;
  logic [bbr_pkg::ChanW-1:0]       in_blue;

  modport source (output valid, drain, in_red, in_green, in_blue, input ready);
  modport sink   (input valid, drain, in_red, in_green, in_blue, output ready);
endinterface

interface bbr_res_if;
  logic                            valid;
  logic                            ready;
  logic [bbr_pkg::ChanW-1:0]       out_red;
  logic [bbr_pkg::ChanW-1:0]       out_green;
  logic [bbr_pkg::ChanW-1:0]       out_blue;
  logic                            row_end;
  logic                            frame_end;

  modport source (output valid, out_red, out_green, out_blue, row_end, frame_end,
                  input ready);
  modport sink   (input valid, out_red, out_green, out_blue, row_end, frame_end,
                  output ready);
endinterface

interface bbr_cfg_if;
  logic                            valid;
  logic                            ready;
  bbr_pkg::cfg_reg_e               reg_index;
  logic [bbr_pkg::CfgDataW-1:0]    wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface
`default_nettype wire

[hw/rtl/bbr_line_buf.sv]
// Two-row line store: one write and one registered read per cycle, write-first.
`default_nettype none
module bbr_line_buf (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      we_i,
  input  wire logic [bbr_pkg::ColW-1:0]  waddr_i,
  input  wire bbr_pkg::lb_word_t         wdata_i,
  input  wire logic [bbr_pkg::ColW-1:0]  raddr_i,
  output bbr_pkg::lb_word_t              rdata_o
);

  bbr_pkg::lb_word_t mem [bbr_pkg::MaxWidth];
  bbr_pkg::lb_word_t rd_q;
  bbr_pkg::lb_word_t byp_data_q;
  logic              byp_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rd_q       <= mem[raddr_i];
    byp_data_q <= wdata_i;
  end

  // same-address write in the read cycle: hand back the new word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else begin
      byp_q <= we_i && (waddr_i == raddr_i);
    end
  end

  assign rdata_o = byp_q ? byp_data_q : rd_q;

endmodule
`default_nettype wire

[hw/rtl/box_blur_3x3_rgb.sv]
// Top level of the streaming 3x3 RGB box blur with black padding.
// Pixels enter in raster order, one beat per clock at full rate; each
// result beat is floor(sum of the 3x3 neighbourhood / 9) per channel,
// with positions outside the frame counted as zero. Result (r,c) comes
// out for the input beat at raster position (r+1)*W + c + 1, so the
// first W+1 beats of a frame give no result; after the last pixel the
// host sends W+1 drain beats (drain=1, or pixels, whose data is ignored)
// to flush the second-to-last row's last pixel and the bottom row. A
// drain beat inside the frame is taken and ignored. A result passes
// through a sum stage, then a divide-by-nine stage into the output
// register. While a finished result waits at the output the input keeps
// moving until the next result fills the sum stage; then the input stalls
// until the output drains. The two previous rows sit in one 1024 x 48-bit
// memory whose next column is read ahead of its use, so the memory port
// sets the one-beat-per-cycle rate. No clearing pass after reset: the top
// two rows of a frame mask the store.
// Register writes (frame_width, frame_height; clamped to 1..1024 and
// 1..4096) restart the frame and must only be issued while the block is
// idle. The last result of a frame carries frame_end and the block then
// starts a new frame.
`default_nettype none
module box_blur_3x3_rgb (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  bbr_pix_if.sink   pix_i,
  bbr_res_if.source res_o,
  bbr_cfg_if.sink   cfg_i
);

  // ---------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------
  logic [bbr_pkg::WidthW-1:0]  width_q, width_d;
  logic [bbr_pkg::HeightW-1:0] height_q, height_d;
  logic [bbr_pkg::WidthW-1:0]  w_eff;
  logic [bbr_pkg::HeightW-1:0] h_eff;
  logic                        cfg_fire;

  assign cfg_i.ready = 1'b1;
  assign cfg_fire    = cfg_i.valid && cfg_i.ready;

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_fire) begin
      case (cfg_i.reg_index)
        bbr_pkg::CFG_FRAME_WIDTH:  width_d  = cfg_i.wdata[bbr_pkg::WidthW-1:0];
        bbr_pkg::CFG_FRAME_HEIGHT: height_d = cfg_i.wdata[bbr_pkg::HeightW-1:0];
        default: ;
      endcase
    end
  end

  // out-of-range sizes clamp: zero acts as one, too large as the maximum
  always_comb begin
    if (width_q == '0) begin
      w_eff = bbr_pkg::WidthW'(1);
    end else if (width_q > bbr_pkg::WidthW'(bbr_pkg::MaxWidth)) begin
      w_eff = bbr_pkg::WidthW'(bbr_pkg::MaxWidth);
    end else begin
      w_eff = width_q;
    end
    if (height_q == '0) begin
      h_eff = bbr_pkg::HeightW'(1);
    end else if (height_q > bbr_pkg::HeightW'(bbr_pkg::HeightLimit)) begin
      h_eff = bbr_pkg::HeightW'(bbr_pkg::HeightLimit);
    end else begin
      h_eff = height_q;
    end
  end

  // ---------------------------------------------------------------
  // Raster position and window
  // ---------------------------------------------------------------
  logic [bbr_pkg::ColW-1:0] col_q, col_d;
  logic [bbr_pkg::RowW-1:0] row_q, row_d;
  // window rows 0..2 (top..bottom), kept columns of the next result:
  // [0] = left, [1] = centre; the right column is the one read now
  bbr_pkg::pix_t            win_q [3][2];
  bbr_pkg::pix_t            win_d [3][2];
  bbr_pkg::pix_t            new_col [3];

  logic          pix_fire, in_frame, step, col_zero, emit, last, col_wrap;
  bbr_pkg::pix_t pix_v;
  bbr_pkg::lb_word_t rd_word, wr_word;

  assign pix_fire = pix_i.valid && pix_i.ready;
  assign in_frame = bbr_pkg::RowW'(row_q) < bbr_pkg::RowW'(h_eff);
  // a drain inside the frame leaves everything as it is
  assign step     = pix_fire && !(in_frame && pix_i.drain);
  assign pix_v    = in_frame ? {pix_i.in_red, pix_i.in_green, pix_i.in_blue} : '0;

  assign col_zero = (col_q == '0);
  assign emit     = col_zero ? (row_q >= bbr_pkg::RowW'(2)) : (row_q >= bbr_pkg::RowW'(1));
  // last pixel of the frame is released at column 0 two rows past it
  assign last     = col_zero && (row_q == bbr_pkg::RowW'(h_eff) + bbr_pkg::RowW'(1));
  assign col_wrap = ({1'b0, col_q} + bbr_pkg::WidthW'(1)) >= w_eff;

  // rows above the frame read as black
  assign new_col[0] = (row_q >= bbr_pkg::RowW'(2)) ? rd_word.upper  : '0;
  assign new_col[1] = (row_q >= bbr_pkg::RowW'(1)) ? rd_word.middle : '0;
  assign new_col[2] = pix_v;

  assign wr_word.upper  = rd_word.middle;
  assign wr_word.middle = pix_v;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    for (int r = 0; r < 3; r++) begin
      win_d[r][0] = win_q[r][0];
      win_d[r][1] = win_q[r][1];
    end
    if (cfg_fire || (step && last)) begin
      col_d = '0;
      row_d = '0;
      for (int r = 0; r < 3; r++) begin
        win_d[r][0] = '0;
        win_d[r][1] = '0;
      end
    end else if (step) begin
      for (int r = 0; r < 3; r++) begin
        // a new row starts with the left neighbour as padding
        win_d[r][0] = col_zero ? '0 : win_q[r][1];
        win_d[r][1] = new_col[r];
      end
      if (col_wrap) begin
        col_d = '0;
        row_d = row_q + bbr_pkg::RowW'(1);
      end else begin
        col_d = col_q + bbr_pkg::ColW'(1);
      end
    end
  end

  // read runs one column ahead so the word for col_q is ready on accept
  bbr_line_buf u_line_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (step),
    .waddr_i (col_q),
    .wdata_i (wr_word),
    .raddr_i (col_d),
    .rdata_o (rd_word)
  );

  // ---------------------------------------------------------------
  // Sum stage: left and centre columns always; right column unless the
  // result is the last pixel of a row (right neighbour is padding)
  // ---------------------------------------------------------------
  bbr_pkg::sums_t sums;

  always_comb begin
    for (int c = 0; c < bbr_pkg::NumChan; c++) begin
      sums[c] = '0;
      for (int r = 0; r < 3; r++) begin
        sums[c] = sums[c] + bbr_pkg::SumW'(win_q[r][0][c])
                          + bbr_pkg::SumW'(win_q[r][1][c])
                          + (col_zero ? '0 : bbr_pkg::SumW'(new_col[r][c]));
      end
    end
  end

  bbr_pkg::sums_t sum_q;
  logic           sum_row_end_q, sum_frame_end_q;
  logic           sum_vld_q, sum_vld_d;
  logic           sum_adv;

  logic           out_vld_q, out_vld_d;
  bbr_pkg::pix_t  out_q;
  logic           out_row_end_q, out_frame_end_q;

  assign sum_adv     = sum_vld_q && (!out_vld_q || res_o.ready);
  assign pix_i.ready = !sum_vld_q || sum_adv;

  always_comb begin
    sum_vld_d = sum_vld_q;
    if (pix_fire) begin
      sum_vld_d = step && emit;
    end else if (sum_adv) begin
      sum_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (sum_adv) begin
      out_vld_d = 1'b1;
    end else if (res_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= bbr_pkg::WidthW'(bbr_pkg::MaxWidth);
      height_q  <= bbr_pkg::HeightW'(1024);
      col_q     <= '0;
      row_q     <= '0;
      sum_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
      for (int r = 0; r < 3; r++) begin
        win_q[r][0] <= '0;
        win_q[r][1] <= '0;
      end
    end else begin
      width_q   <= width_d;
      height_q  <= height_d;
      col_q     <= col_d;
      row_q     <= row_d;
      sum_vld_q <= sum_vld_d;
      out_vld_q <= out_vld_d;
      for (int r = 0; r < 3; r++) begin
        win_q[r][0] <= win_d[r][0];
        win_q[r][1] <= win_d[r][1];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (step && emit) begin
      sum_q           <= sums;
      sum_row_end_q   <= col_zero;
      sum_frame_end_q <= last;
    end
    if (sum_adv) begin
      for (int c = 0; c < bbr_pkg::NumChan; c++) begin
        out_q[c] <= bbr_pkg::div9(sum_q[c]);
      end
      out_row_end_q   <= sum_row_end_q;
      out_frame_end_q <= sum_frame_end_q;
    end
  end

  assign res_o.valid     = out_vld_q;
  assign res_o.out_red   = out_q[2];
  assign res_o.out_green = out_q[1];
  assign res_o.out_blue  = out_q[0];
  assign res_o.row_end   = out_row_end_q;
  assign res_o.frame_end = out_frame_end_q;

endmodule
`default_nettype wire

[dv/testbench.sv]
// Self-checking testbench for the streaming 3x3 RGB box blur.
module testbench;
  import bbr_pkg::*;

  localparam int unsigned CycleLimit = 1000000;

  typedef struct packed {
    logic             drain;
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } pix_beat_t;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic             row_end;
    logic             frame_end;
  } blur_res_t;

  typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_e;

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  always #4 clk_i = ~clk_i;

  // locally held drive values, all known from time zero
  logic                pix_valid = 1'b0;
  pix_beat_t           pix_beat  = '0;
  logic                res_ready = 1'b1;
  logic                cfg_valid = 1'b0;
  cfg_reg_e            cfg_index = CFG_FRAME_WIDTH;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  bbr_pix_if pix_if ();
  bbr_res_if res_if ();
  bbr_cfg_if cfg_if ();

  assign pix_if.valid     = pix_valid;
  assign pix_if.drain     = pix_beat.drain;
  assign pix_if.in_red    = pix_beat.red;
  assign pix_if.in_green  = pix_beat.green;
  assign pix_if.in_blue   = pix_beat.blue;
  assign res_if.ready     = res_ready;
  assign cfg_if.valid     = cfg_valid;
  assign cfg_if.reg_index = cfg_index;
  assign cfg_if.wdata     = cfg_wdata;

  box_blur_3x3_rgb u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  // ---------------------------------------------------------------------------
  // Blur predictor: own copy of line stores, window, raster position and regs
  // ---------------------------------------------------------------------------
  pix_t               upper_mem  [MaxWidth];
  pix_t               middle_mem [MaxWidth];
  pix_t               win        [9];
  int unsigned        pos_row    = 0;
  int unsigned        pos_col    = 0;
  logic [WidthW-1:0]  width_reg  = WidthW'(1024);
  logic [HeightW-1:0] height_reg = HeightW'(1024);

  initial foreach (win[k]) win[k] = '0;

  task automatic restart_frame();
    pos_row = 0;
    pos_col = 0;
    foreach (win[k]) win[k] = '0;
  endtask

  task automatic apply_reg(input cfg_reg_e idx, input logic [CfgDataW-1:0] val);
    case (idx)
      CFG_FRAME_WIDTH:  width_reg  = val[WidthW-1:0];
      CFG_FRAME_HEIGHT: height_reg = val[HeightW-1:0];
      default: ;
    endcase
    restart_frame();
  endtask

  // one accepted beat in, zero or one blurred pixel out
  task automatic predict_blur(input pix_beat_t beat, output bit emit, output blur_res_t res);
    int unsigned w, h, i, j, crow, ccol, sum_r, sum_g, sum_b;
    bit          last;
    pix_t        v, top, mid;
    pix_t        taps [9];
    w = (width_reg == 0) ? 1 : ((width_reg > MaxWidth) ? MaxWidth : width_reg);
    h = (height_reg == 0) ? 1 : ((height_reg > HeightLimit) ? HeightLimit : height_reg);
    i = pos_row;
    j = pos_col;
    emit = 1'b0;
    res  = '0;
    crow = 0;
    ccol = 0;
    // a drain while the frame is still being fed is dropped
    if (!(i < h && beat.drain)) begin
      // past the last row every beat pushes black, pixel data or not
      v   = (i < h) ? pix_t'({beat.red, beat.green, beat.blue}) : '0;
      top = (i >= 2) ? upper_mem[j] : '0;
      mid = (i >= 1) ? middle_mem[j] : '0;
      upper_mem[j]  = middle_mem[j];
      middle_mem[j] = v;
      if (j == 0) begin
        // closes the last column of the row two above; right side is padding
        for (int r = 0; r < 3; r++) begin
          taps[r*3]     = win[r*3+1];
          taps[r*3+1]   = win[r*3+2];
          taps[r*3+2]   = '0;
          win[r*3]      = '0;
          win[r*3+1]    = '0;
        end
        if (i >= 2) begin
          emit = 1'b1;
          crow = i - 2;
          ccol = w - 1;
        end
      end else begin
        for (int r = 0; r < 3; r++) begin
          win[r*3]   = win[r*3+1];
          win[r*3+1] = win[r*3+2];
        end
        if (i >= 1) begin
          emit = 1'b1;
          crow = i - 1;
          ccol = j - 1;
        end
      end
      win[2] = top;
      win[5] = mid;
      win[8] = v;
      if (j != 0) taps = win;
      if (j + 1 >= w) begin
        pos_col = 0;
        pos_row = i + 1;
      end else begin
        pos_col = j + 1;
      end
      if (emit) begin
        sum_r = 0;
        sum_g = 0;
        sum_b = 0;
        for (int k = 0; k < 9; k++) begin
          sum_r += taps[k][2];
          sum_g += taps[k][1];
          sum_b += taps[k][0];
        end
        last          = (crow == h - 1) && (ccol == w - 1);
        res.red       = ChanW'(sum_r / 9);
        res.green     = ChanW'(sum_g / 9);
        res.blue      = ChanW'(sum_b / 9);
        res.row_end   = (ccol == w - 1);
        res.frame_end = last;
        if (last) restart_frame();
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Pixel driver: bursts with random gaps, fed from pixel_q
  // ---------------------------------------------------------------------------
  pix_beat_t   pixel_q [$];
  logic        pix_taken  = 1'b0;
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;

  always @(negedge clk_i) begin : drive_pixels
    pix_beat_t nxt;
    if (rst_ni && !(pix_valid && !pix_taken)) begin
      if (gap_left != 0) begin
        pix_valid <= 1'b0;
        gap_left  <= gap_left - 1;
      end else if (pixel_q.size() != 0) begin
        nxt = pixel_q.pop_front();
        pix_beat  <= nxt;
        pix_valid <= 1'b1;
        if (burst_left <= 1) begin
          // now and then a long burst with no gap at all
          if ($urandom_range(0, 5) == 0) begin
            burst_left <= $urandom_range(100, 300);
            gap_left   <= 0;
          end else begin
            burst_left <= $urandom_range(1, 40);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        pix_valid <= 1'b0;
      end
    end
  end

  // result sink: stall behavior switches between modes every so often
  rx_mode_e    rx_mode   = RX_OPEN;
  int unsigned rx_left   = 0;
  int unsigned rx_period = 2;

  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode   <= rx_mode_e'($urandom_range(0, 3));
      rx_left   <= $urandom_range(16, 200);
      rx_period <= $urandom_range(2, 5);
      res_ready <= 1'b1;
    end else begin
      rx_left <= rx_left - 1;
      case (rx_mode)
        RX_LIGHT:    res_ready <= ($urandom_range(0, 3) != 0);
        RX_HEAVY:    res_ready <= ($urandom_range(0, 9) < 4);
        RX_PERIODIC: res_ready <= ((rx_left % rx_period) != 0);
        default:     res_ready <= 1'b1;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predicts on every accepted beat, checks every accepted result
  // ---------------------------------------------------------------------------
  blur_res_t   blur_exp_q [$];
  int unsigned err_cnt = 0;
  int unsigned res_cnt = 0;

  task automatic report(input string what);
    err_cnt++;
    if (err_cnt <= 10) $display("%s", what);
  endtask

  always @(posedge clk_i) begin : watch
    bit        got;
    blur_res_t want, seen;
    pix_taken <= pix_if.valid && pix_if.ready;
    if (rst_ni) begin
      if (cfg_if.valid && cfg_if.ready) apply_reg(cfg_if.reg_index, cfg_if.wdata);
      // beat first: a result of this very edge can only be older or this one
      if (pix_if.valid && pix_if.ready) begin
        predict_blur(pix_beat_t'({pix_if.drain, pix_if.in_red, pix_if.in_green,
                                  pix_if.in_blue}), got, want);
        if (got) blur_exp_q.push_back(want);
      end
      if (res_if.valid && res_if.ready) begin
        seen = '{res_if.out_red, res_if.out_green, res_if.out_blue,
                 res_if.row_end, res_if.frame_end};
        if (blur_exp_q.size() == 0) begin
          report($sformatf("result %0d unexpected: r=%0d g=%0d b=%0d row_end=%0b frame_end=%0b",
                           res_cnt, seen.red, seen.green, seen.blue, seen.row_end,
                           seen.frame_end));
        end else begin
          want = blur_exp_q.pop_front();
          if (seen.red !== want.red || seen.green !== want.green || seen.blue !== want.blue ||
              seen.row_end !== want.row_end || seen.frame_end !== want.frame_end)
            report($sformatf({"result %0d mismatch: exp r=%0d g=%0d b=%0d re=%0b fe=%0b,",
                              " got r=%0d g=%0d b=%0d re=%0b fe=%0b"},
                             res_cnt, want.red, want.green, want.blue, want.row_end,
                             want.frame_end, seen.red, seen.green, seen.blue, seen.row_end,
                             seen.frame_end));
        end
        res_cnt++;
      end
    end
  end

  // watchdog
  int unsigned cycle_cnt = 0;
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  function automatic logic [ChanW-1:0] pick_chan();
    case ($urandom_range(0, 7))
      0:       return '1;
      1:       return '0;
      default: return ChanW'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic queue_beat(input bit drain, input logic [ChanW-1:0] r, g, b);
    pixel_q.push_back('{drain: drain, red: r, green: g, blue: b});
  endtask

  // npix pixels of a w x h frame, drains sprinkled in at 1/odds (0 = none);
  // a full frame gets its w+1 flush beats, a mix of drains and dead pixels
  task automatic run_frame(input int unsigned w, h, npix, odds, input bit full,
                           output int unsigned counted);
    int unsigned sent;
    sent = 0;
    while (sent < npix) begin
      if (odds != 0 && $urandom_range(1, odds) == 1) begin
        queue_beat(1'b1, pick_chan(), pick_chan(), pick_chan());
      end else begin
        queue_beat(1'b0, pick_chan(), pick_chan(), pick_chan());
        sent++;
      end
    end
    counted = npix;
    if (full) begin
      for (int unsigned k = 0; k <= w; k++)
        queue_beat($urandom_range(0, 2) != 0, pick_chan(), pick_chan(), pick_chan());
      counted += w + 1;
    end
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // all beats taken, all results back, plus a margin for the pipeline
  task automatic wait_for_quiet();
    while (pixel_q.size() != 0 || pix_valid || blur_exp_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  initial begin : stimulus
    int unsigned        n, rand_items, w_eff, h_eff, npix;
    logic [CfgDataW-1:0] w_val, h_val;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // a few pixels under the reset geometry, then cut off by register writes
    run_frame(1024, 1024, 3, 0, 1'b0, n);
    wait_for_quiet();

    // 3x3 frame: extremes, a drain inside the frame, dead pixels in the flush
    write_reg(CFG_FRAME_WIDTH, CfgDataW'(3));
    write_reg(CFG_FRAME_HEIGHT, CfgDataW'(3));
    queue_beat(1'b0, 8'hFF, 8'hFF, 8'hFF);
    queue_beat(1'b0, 8'h00, 8'h00, 8'h00);
    queue_beat(1'b0, 8'hFF, 8'h00, 8'h80);
    queue_beat(1'b1, 8'h55, 8'hAA, 8'h55);
    queue_beat(1'b0, 8'h00, 8'hFF, 8'h00);
    queue_beat(1'b0, 8'hFF, 8'hFF, 8'hFF);
    queue_beat(1'b0, 8'h01, 8'h02, 8'h03);
    queue_beat(1'b0, 8'h00, 8'h00, 8'hFF);
    queue_beat(1'b0, 8'h80, 8'h80, 8'h80);
    queue_beat(1'b0, 8'hFF, 8'hFF, 8'hFF);
    queue_beat(1'b1, 8'h00, 8'h00, 8'h00);
    queue_beat(1'b0, 8'h07, 8'h07, 8'h07);
    queue_beat(1'b1, 8'hFF, 8'hFF, 8'hFF);
    queue_beat(1'b0, 8'hFF, 8'hFF, 8'hFF);
    // lands in the next frame, so it is dropped
    queue_beat(1'b1, 8'h12, 8'h34, 8'h56);
    wait_for_quiet();

    // single pixel frame, written directly and through the zero clamp
    write_reg(CFG_FRAME_WIDTH, CfgDataW'(1));
    write_reg(CFG_FRAME_HEIGHT, CfgDataW'(1));
    queue_beat(1'b0, 8'hFF, 8'hFF, 8'hFF);
    queue_beat(1'b1, 8'h00, 8'h00, 8'h00);
    queue_beat(1'b0, 8'h9C, 8'h3E, 8'h01);
    wait_for_quiet();
    write_reg(CFG_FRAME_WIDTH, '0);
    write_reg(CFG_FRAME_HEIGHT, '0);
    run_frame(1, 1, 1, 0, 1'b1, n);
    wait_for_quiet();

    // one column, height through the upper clamp; broken off after a few rows
    write_reg(CFG_FRAME_WIDTH, CfgDataW'(1));
    write_reg(CFG_FRAME_HEIGHT, '1);
    run_frame(1, HeightLimit, 12, 0, 1'b0, n);
    wait_for_quiet();

    // oversized width clamps to the store depth; broken off early
    write_reg(CFG_FRAME_WIDTH, '1);
    write_reg(CFG_FRAME_HEIGHT, CfgDataW'(2));
    run_frame(1024, 2, 6, 0, 1'b0, n);
    wait_for_quiet();

    // random frames, mostly complete, a few broken off mid-frame
    rand_items = 0;
    w_val = '0;
    h_val = '0;
    while (rand_items < 1100) begin
      case ($urandom_range(0, 19))
        0:       n = 0;
        1:       n = $urandom_range(13, 40);
        default: n = $urandom_range(1, 12);
      endcase
      // bits above the 11-bit register field must be dropped
      w_val = {CfgDataW'($urandom_range(0, 3)) << WidthW} | CfgDataW'(n);
      h_val = ($urandom_range(0, 9) == 0) ? '0 : CfgDataW'($urandom_range(1, 8));
      case ($urandom_range(0, 3))
        0:       write_reg(CFG_FRAME_WIDTH, w_val);
        1:       write_reg(CFG_FRAME_HEIGHT, h_val);
        default: begin
          write_reg(CFG_FRAME_HEIGHT, h_val);
          write_reg(CFG_FRAME_WIDTH, w_val);
        end
      endcase
      w_eff = (width_reg == 0) ? 1 : width_reg;
      h_eff = (height_reg == 0) ? 1 : height_reg;
      if ($urandom_range(0, 7) == 0) begin
        npix = $urandom_range(0, w_eff * h_eff - 1);
        run_frame(w_eff, h_eff, npix, 8, 1'b0, n);
      end else begin
        run_frame(w_eff, h_eff, w_eff * h_eff, ($urandom_range(0, 1) == 0) ? 0 : 8, 1'b1, n);
        // stray drains after the frame fall into the next one and are dropped
        if ($urandom_range(0, 3) == 0)
          repeat ($urandom_range(1, 3)) queue_beat(1'b1, pick_chan(), pick_chan(), pick_chan());
      end
      rand_items += n;
      wait_for_quiet();
    end

    repeat (16) @(posedge clk_i);
    if (err_cnt == 0 && blur_exp_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
